>>> hdl/ppm_frame_decoder_unit_macros.svh
// Assertion macros for the PPM frame decoder.
// Taken in by the files that check the design; no other dependencies.
`ifndef PPM_FRAME_DECODER_UNIT_MACROS_SVH
`define PPM_FRAME_DECODER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset
`define PPM_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("ppm_frame_decoder: check failed");
// Next-cycle implication
`define PPM_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("ppm_frame_decoder: check failed");
`else
`define PPM_ASSERT_IMP(lbl, clk, rstn, a, c)
`define PPM_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

>>> hdl/ppm_fd_pkg.sv
// Shared types and constants for the PPM frame decoder.
// No dependencies; used by the front, back and top-level modules.
package ppm_fd_pkg;

    // Request kinds carried on the input tuser bit
    typedef enum logic {
        REQ_CAPTURE = 1'b0,
        REQ_READ    = 1'b1
    } req_type_t;

    // Result kinds carried on the output tuser bits
    typedef enum logic [1:0] {
        EV_IDLE      = 2'd0,
        EV_HEADER    = 2'd1,
        EV_CHANNEL   = 2'd2,
        EV_SYNC_LOST = 2'd3
    } event_kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_COUNTER_TOP = 2'd0,
        CFG_HEADER_MIN  = 2'd1,
        CFG_PULSE_MAX   = 2'd2,
        CFG_PULSE_MIN   = 2'd3
    } cfg_reg_t;

    localparam logic [31:0] COUNTER_TOP_RST = 32'd65535;
    localparam logic [15:0] HEADER_MIN_RST  = 16'd5000;
    localparam logic [15:0] PULSE_MAX_RST   = 16'd2500;
    localparam logic [15:0] PULSE_MIN_RST   = 16'd500;

    // Classified input item as held in the queue
    typedef struct packed {
        req_type_t   req;
        logic [31:0] capture_time;
        logic [3:0]  read_slot;
        logic        rd_in_range;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    // One result transaction
    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  slot_written;
        logic [31:0] interval;
        logic [3:0]  frame_channels;
        logic [31:0] read_data;
    } result_t;

endpackage

>>> hdl/ppm_fd_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on ppm_fd_pkg.
module ppm_fd_front
    import ppm_fd_pkg::*;
#(
    parameter int SLOT_COUNT = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // capture_time[31:0], read_slot[35:32], zero pad
    input  logic        s_axis_tuser,   // req_type
    output q_head_t     head,
    input  logic        pop
);

    localparam logic [4:0] SLOT_LIM = 5'(SLOT_COUNT);

    item_t       q_mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    item_t       in_item;

    // Decode and classify the incoming transaction
    always_comb
    begin
        in_item.req          = req_type_t'(s_axis_tuser);
        in_item.capture_time = s_axis_tdata[31:0];
        in_item.read_slot    = s_axis_tdata[35:32];
        in_item.rd_in_range  = ({1'b0, s_axis_tdata[35:32]} < SLOT_LIM);
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;

    // Two-entry queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

endmodule

>>> hdl/ppm_fd_back.sv
// Back end: interval tracking, sync state, channel store and result register.
// Depends on ppm_fd_pkg.
module ppm_fd_back
    import ppm_fd_pkg::*;
#(
    parameter int SLOT_COUNT   = 12,
    parameter int UNSYNCED_POS = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_head_t     head,
    output logic        pop,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data
);

    localparam int         IDX_W    = $clog2(SLOT_COUNT);
    localparam logic [4:0] SLOT_LIM = 5'(SLOT_COUNT);
    localparam logic [3:0] UNSYNC   = 4'(UNSYNCED_POS);

    logic [31:0] counter_top_reg;
    logic [15:0] header_min_reg;
    logic [15:0] pulse_max_reg;
    logic [15:0] pulse_min_reg;

    logic [31:0] last_stamp_reg;
    logic [31:0] last_stamp_next;
    logic [31:0] interval_reg;
    logic [31:0] interval_next;
    logic [3:0]  position_reg;
    logic [3:0]  position_next;
    logic [3:0]  latched_reg;
    logic [3:0]  latched_next;
    logic [31:0] store_reg [SLOT_COUNT];

    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_data_reg;
    result_t     out_data_next;

    logic [31:0] now;
    logic [31:0] diff_fwd;
    logic [31:0] diff_wrap;
    logic [31:0] iv_calc;
    logic        in_pulse;
    logic        is_header;
    logic [3:0]  pos_inc;
    logic        wr_en;
    logic [3:0]  wr_slot;
    logic        store_we;
    event_kind_t kind;
    logic [3:0]  written;
    logic [31:0] rdata;

    // Take the next queued item whenever the result register is free
    assign pop = head.valid && (!out_valid_reg || out_ready);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_top_reg <= COUNTER_TOP_RST;
            header_min_reg  <= HEADER_MIN_RST;
            pulse_max_reg   <= PULSE_MAX_RST;
            pulse_min_reg   <= PULSE_MIN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_COUNTER_TOP: counter_top_reg <= cfg_data;
                CFG_HEADER_MIN:  header_min_reg  <= cfg_data[15:0];
                CFG_PULSE_MAX:   pulse_max_reg   <= cfg_data[15:0];
                CFG_PULSE_MIN:   pulse_min_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // Wrap-corrected interval; a zero previous stamp keeps the old value
    assign now       = head.item.capture_time;
    assign diff_fwd  = now - last_stamp_reg;
    assign diff_wrap = now + counter_top_reg - last_stamp_reg;
    assign iv_calc   = (last_stamp_reg == 32'd0) ? interval_reg :
                       (now > last_stamp_reg) ? diff_fwd : diff_wrap;

    assign in_pulse  = (iv_calc <= {16'd0, pulse_max_reg}) &&
                       (iv_calc > {16'd0, pulse_min_reg});
    assign is_header = (iv_calc > {16'd0, header_min_reg});
    assign pos_inc   = position_reg + 4'd1;

    // Classify the interval and update sync state
    always_comb
    begin
        last_stamp_next = last_stamp_reg;
        interval_next   = interval_reg;
        position_next   = position_reg;
        latched_next    = latched_reg;
        wr_en           = 1'b0;
        wr_slot         = 4'd0;
        kind            = EV_IDLE;
        written         = 4'd0;
        rdata           = 32'd0;
        if (pop)
        begin
            if (head.item.req == REQ_READ)
            begin
                if (head.item.rd_in_range)
                begin
                    rdata = store_reg[head.item.read_slot[IDX_W-1:0]];
                end
            end
            else
            begin
                interval_next   = iv_calc;
                last_stamp_next = now;
                if (position_reg != UNSYNC)
                begin
                    if (in_pulse)
                    begin
                        // pulse window wins over the header test
                        position_next = pos_inc;
                        wr_en         = 1'b1;
                        wr_slot       = pos_inc;
                        written       = pos_inc;
                        kind          = (pos_inc == UNSYNC) ? EV_SYNC_LOST : EV_CHANNEL;
                    end
                    else if (is_header)
                    begin
                        latched_next  = position_reg;
                        position_next = 4'd0;
                        wr_en         = 1'b1;
                        kind          = EV_HEADER;
                    end
                    else
                    begin
                        position_next = UNSYNC;
                        kind          = EV_SYNC_LOST;
                    end
                end
                else if (is_header)
                begin
                    // header while unsynced keeps the latched count
                    position_next = 4'd0;
                    wr_en         = 1'b1;
                    kind          = EV_HEADER;
                end
            end
        end
    end

    // Slots past the end of the store are dropped
    assign store_we = wr_en && ({1'b0, wr_slot} < SLOT_LIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= 32'd0;
            interval_reg   <= 32'd0;
            position_reg   <= UNSYNC;
            latched_reg    <= 4'd0;
        end
        else
        begin
            last_stamp_reg <= last_stamp_next;
            interval_reg   <= interval_next;
            position_reg   <= position_next;
            latched_reg    <= latched_next;
        end
    end

    // Channel store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                store_reg[i] <= 32'd0;
            end
        end
        else if (store_we)
        begin
            store_reg[wr_slot[IDX_W-1:0]] <= iv_calc;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next               = 1'b1;
            out_data_next.kind           = kind;
            out_data_next.slot_written   = written;
            out_data_next.interval       = interval_next;
            out_data_next.frame_channels = latched_next;
            out_data_next.read_data      = rdata;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hdl/ppm_frame_decoder_unit.sv
// PPM frame decoder top level: front end, queue, back end and output packing.
// Depends on ppm_fd_pkg, ppm_fd_front, ppm_fd_back and the macros header.
//
// Usage:
//   s_axis carries one request per transaction: tuser selects a timer capture
//   (0) or a read of one stored channel slot (1). Every request gives exactly
//   one m_axis transaction with the event kind in tuser and the slot written,
//   current interval, latched channel count and read data in tdata.
//   The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   counter top, header threshold and pulse window; cfg_ready is always high.
//   Write it only while no request is in flight.
// Path: an accepted request is first written into the two-entry queue; the back end
//   then takes the queue entry and writes the result register.
//   Throughput: one transaction per cycle while m_axis_tready stays high; the back end
//   updates the interval, sync state and channel store as it takes each item.
// Reset: the counter starts unsynced, stamps, interval and all channel
//   slots clear to zero, configuration returns to its defaults.
// Stall: the result register holds while m_axis_tready is low; the two-entry
//   queue keeps taking requests until full, then s_axis_tready drops.
`include "ppm_frame_decoder_unit_macros.svh"
module ppm_frame_decoder_unit
    import ppm_fd_pkg::*;
#(
    parameter int SLOT_COUNT   = 12,
    parameter int UNSYNCED_POS = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // capture_time[31:0], read_slot[35:32], zero pad
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // slot_written[3:0], interval[35:4],
                                        // frame_channels[39:36], read_data[71:40]
    output logic [1:0]  m_axis_tuser,   // event_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    q_head_t head;
    logic    pop;
    result_t res;

    ppm_fd_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .pop           (pop)
    );

    ppm_fd_back #(
        .SLOT_COUNT   (SLOT_COUNT),
        .UNSYNCED_POS (UNSYNCED_POS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign cfg_ready = 1'b1;

    // Output packing
    assign m_axis_tuser  = res.kind;
    assign m_axis_tdata  = {res.read_data, res.frame_channels, res.interval, res.slot_written};

    // A stored channel never lands in slot zero
    `PPM_ASSERT_IMP(a_chan_slot_nonzero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == EV_CHANNEL), m_axis_tdata[3:0] != 4'd0)
    // A header result names no written slot
    `PPM_ASSERT_IMP(a_header_no_slot, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == EV_HEADER), m_axis_tdata[3:0] == 4'd0)
    // Read data only appears on read results
    `PPM_ASSERT_IMP(a_rdata_on_read, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[71:40] != 32'd0), m_axis_tuser == EV_IDLE)
    // An accepted request is queued for the back end on the next cycle
    `PPM_ASSERT_NXT(a_push_queued, clk, rst_n,
        s_axis_tvalid && s_axis_tready, head.valid)

endmodule

>>> verif/ppm_frame_decoder_unit_checker.sv
// Result checker for the PPM frame decoder: watches the cfg, s_axis and m_axis channels.
// Keeps its own decoder state and compares every output transaction with it.
// Depends on ppm_fd_pkg only.
`timescale 1ns / 100ps

module ppm_frame_decoder_unit_checker
    import ppm_fd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // capture_time[31:0], read_slot[35:32], zero pad
    input  logic        s_axis_tuser,   // req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,   // slot_written[3:0], interval[35:4],
                                        // frame_channels[39:36], read_data[71:40]
    input  logic [1:0]  m_axis_tuser,   // event_kind
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          outstanding
);

    localparam int         SLOT_COUNT   = 12;
    localparam logic [3:0] UNSYNC_POS   = 4'd11;
    localparam int         REPORT_LIMIT = 100;

    // Programmed thresholds
    logic [31:0] wrap_top;
    logic [15:0] header_thr;
    logic [15:0] width_max;
    logic [15:0] width_min;

    // Decoder state
    logic [31:0] prev_stamp;
    logic [31:0] cur_interval;
    logic [3:0]  slot_pos;
    logic [31:0] chan_width [0:SLOT_COUNT-1];
    logic [3:0]  chan_count;

    result_t pending_results [$];

    task automatic clear_decoder();
        wrap_top     = COUNTER_TOP_RST;
        header_thr   = HEADER_MIN_RST;
        width_max    = PULSE_MAX_RST;
        width_min    = PULSE_MIN_RST;
        prev_stamp   = '0;
        cur_interval = '0;
        slot_pos     = UNSYNC_POS;
        chan_count   = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            chan_width[i] = '0;
        end
    endtask

    // Advance the decoder by one request and return the result it yields
    function automatic result_t decode_request(input logic req, input logic [31:0] stamp,
                                               input logic [3:0] rd_slot);
        result_t r;
        logic    in_window;
        r.kind         = EV_IDLE;
        r.slot_written = '0;
        r.read_data    = '0;
        if (req == REQ_READ)
        begin
            if (rd_slot < SLOT_COUNT)
                r.read_data = chan_width[rd_slot];
        end
        else
        begin
            // a zero previous stamp keeps the old interval
            if (prev_stamp != '0)
            begin
                if (stamp > prev_stamp)
                    cur_interval = stamp - prev_stamp;
                else
                    cur_interval = stamp + wrap_top - prev_stamp;
            end
            prev_stamp = stamp;
            in_window  = (cur_interval <= {16'd0, width_max}) &&
                         (cur_interval > {16'd0, width_min});
            if (slot_pos != UNSYNC_POS)
            begin
                // pulse window wins over the header test
                if (in_window)
                begin
                    slot_pos = slot_pos + 4'd1;
                    if (slot_pos < SLOT_COUNT)
                        chan_width[slot_pos] = cur_interval;
                    r.slot_written = slot_pos;
                    r.kind = (slot_pos == UNSYNC_POS) ? EV_SYNC_LOST : EV_CHANNEL;
                end
                else if (cur_interval > {16'd0, header_thr})
                begin
                    chan_count    = slot_pos;
                    slot_pos      = '0;
                    chan_width[0] = cur_interval;
                    r.kind        = EV_HEADER;
                end
                else
                begin
                    slot_pos = UNSYNC_POS;
                    r.kind   = EV_SYNC_LOST;
                end
            end
            else if (cur_interval > {16'd0, header_thr})
            begin
                // header while unsynced keeps the latched count
                slot_pos      = '0;
                chan_width[0] = cur_interval;
                r.kind        = EV_HEADER;
            end
        end
        r.interval       = cur_interval;
        r.frame_channels = chan_count;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        mismatch_count++;
    endtask

    // Track every transaction on the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_decoder();
            pending_results.delete();
            mismatch_count = 0;
            outstanding    <= 0;
        end
        else
        begin : track
            result_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: result with none expected, expected none, actual %0h/%0h",
                                 $time, m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser != want.kind)
                        note_mismatch("event_kind", 32'(want.kind), 32'(m_axis_tuser));
                    if (m_axis_tdata[3:0] != want.slot_written)
                        note_mismatch("slot_written", 32'(want.slot_written),
                                      32'(m_axis_tdata[3:0]));
                    if (m_axis_tdata[35:4] != want.interval)
                        note_mismatch("interval", want.interval, m_axis_tdata[35:4]);
                    if (m_axis_tdata[39:36] != want.frame_channels)
                        note_mismatch("frame_channels", 32'(want.frame_channels),
                                      32'(m_axis_tdata[39:36]));
                    if (m_axis_tdata[71:40] != want.read_data)
                        note_mismatch("read_data", want.read_data, m_axis_tdata[71:40]);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_COUNTER_TOP: wrap_top   = cfg_data;
                    CFG_HEADER_MIN:  header_thr = cfg_data[15:0];
                    CFG_PULSE_MAX:   width_max  = cfg_data[15:0];
                    CFG_PULSE_MIN:   width_min  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(decode_request(s_axis_tuser, s_axis_tdata[31:0],
                                                         s_axis_tdata[35:32]));
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> verif/ppm_frame_decoder_unit_tb.sv
// Testbench top for the PPM frame decoder: clock, reset, stimulus and verdict.
// Depends on ppm_fd_pkg, ppm_frame_decoder_unit and ppm_frame_decoder_unit_checker.
`timescale 1ns / 100ps

module ppm_frame_decoder_unit_tb;
    import ppm_fd_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_ITEMS    = 160;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [31:0] cfg_data      = '0;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;

    // Generator view of the programmed thresholds and the free-running timer
    logic [31:0] cur_top = COUNTER_TOP_RST;
    logic [15:0] cur_hdr = HEADER_MIN_RST;
    logic [15:0] cur_max = PULSE_MAX_RST;
    logic [15:0] cur_min = PULSE_MIN_RST;
    logic [31:0] timer_now = '0;
    int          burst_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ppm_frame_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ppm_frame_decoder_unit_checker u_frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure: the pattern is redrawn from four modes whenever its run ends
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;
    int pat_ctr    = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(64, 256);
            end
            mode_left--;
            pat_ctr++;
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ((pat_ctr % 7) >= 3);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        m_axis_tready <= 1'b0;
                    end
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left = $urandom_range(4, 12);
                        m_axis_tready <= 1'b0;
                    end
                    else
                        m_axis_tready <= 1'b1;
                end
            endcase
        end
    end

    // One request transaction, with bursts and random gaps on the sender side
    task automatic send_item(input req_type_t req, input logic [31:0] stamp,
                             input logic [3:0] slot);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, slot, stamp};
        s_axis_tuser  <= req;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic capture_at(input logic [31:0] stamp);
        logic [3:0] junk;
        junk      = 4'($urandom_range(0, 15));
        timer_now = stamp;
        send_item(REQ_CAPTURE, stamp, junk);
    endtask

    // Capture an edge a given number of ticks after the last one, wrapping at the top
    task automatic capture_after(input logic [63:0] ticks);
        logic [63:0] t;
        t = {32'd0, timer_now} + ticks;
        if (t > {32'd0, cur_top})
            t = t - {32'd0, cur_top};
        capture_at(t[31:0]);
    endtask

    task automatic read_slot(input logic [3:0] slot);
        send_item(REQ_READ, $urandom, slot);
    endtask

    function automatic logic [63:0] pulse_ticks();
        if (cur_max <= cur_min)
            return 64'($urandom_range(1, 3000));
        case ($urandom_range(0, 7))
            0: return {48'd0, cur_min} + 64'd1;
            1: return {48'd0, cur_max};
            default: return 64'($urandom_range(cur_min + 1, cur_max));
        endcase
    endfunction

    function automatic logic [63:0] header_ticks();
        if ($urandom_range(0, 3) == 0)
            return {48'd0, cur_hdr} + 64'd1;
        return {48'd0, cur_hdr} + 64'd1 + 64'($urandom_range(0, 4000));
    endfunction

    // Broken interval: at or below the pulse minimum, above the pulse maximum, or up to the header
    function automatic logic [63:0] broken_ticks();
        case ($urandom_range(0, 2))
            0: return 64'($urandom_range(0, cur_min));
            1: return {48'd0, cur_max} + 64'd1 + 64'($urandom_range(0, 2000));
            default: return 64'($urandom_range(0, cur_hdr));
        endcase
    endfunction

    // Hold off until every result is back and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers; upper bits of the 16-bit ones carry junk
    task automatic program_regs(input logic [31:0] top, input logic [15:0] hdr,
                                input logic [15:0] pmax, input logic [15:0] pmin);
        drain();
        cur_top = top;
        cur_hdr = hdr;
        cur_max = pmax;
        cur_min = pmin;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_COUNTER_TOP;
        cfg_data  <= top;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_HEADER_MIN;
        cfg_data  <= {16'($urandom), hdr};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_PULSE_MAX;
        cfg_data  <= {16'($urandom), pmax};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_PULSE_MIN;
        cfg_data  <= {16'($urandom), pmin};
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames, with reads, noise and broken pulses mixed in
    task automatic random_frames(input int count);
        int done;
        int sel;
        int chans;
        done = 0;
        while (done < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                capture_after(header_ticks());
                done++;
                chans = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13)
                                                    : $urandom_range(0, 9);
                for (int i = 0; i < chans; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        capture_after(broken_ticks());
                    else
                        capture_after(pulse_ticks());
                    done++;
                end
            end
            else if (sel < 80)
            begin
                read_slot(4'($urandom_range(0, 15)));
                done++;
            end
            else if (sel < 90)
            begin
                capture_at(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
                done++;
            end
            else
            begin
                capture_after(64'($urandom_range(0, 70000)));
                done++;
            end
        end
    endtask

    initial
    begin
        logic [15:0] lo;
        logic [15:0] hi;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks on the reset thresholds
        read_slot(4'd0);
        capture_at(32'd0);              // zero previous stamp
        capture_at(32'd1000);           // still zero previous, interval held
        capture_after(64'd5000);        // unsynced, exactly the header threshold
        capture_after(64'd5001);        // header while unsynced
        capture_after(64'd501);         // just inside the pulse window
        capture_after(64'd2500);        // top of the pulse window
        capture_after(64'd500);         // pulse minimum itself drops sync
        capture_after(64'd5001);
        capture_after(64'd2501);        // just above pulse max drops sync
        capture_after(64'd6000);
        for (int i = 0; i < 11; i++)
            capture_after(64'd1000 + 64'(i * 100));   // last one lands on the unsynced slot
        capture_after({32'd0, cur_top}); // same stamp again: full wrap
        capture_after(64'd1500);
        capture_after(64'd5001);        // synced header latches the count
        capture_after(64'd5000);        // synced, neither pulse nor header
        capture_after(64'd20000);       // wraps past the counter top
        capture_at(32'd0);
        capture_after(64'd1200);
        read_slot(4'd11);
        read_slot(4'd12);
        read_slot(4'd15);
        random_frames(PHASE_ITEMS);

        program_regs(32'd40000, 16'd3000, 16'd2000, 16'd900);
        random_frames(PHASE_ITEMS);

        program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        timer_now = 32'hFFFF_0000;
        random_frames(PHASE_ITEMS);

        program_regs(32'd1, 16'd0, 16'd0, 16'd0);
        random_frames(PHASE_ITEMS);

        // pulse window overlapping the header range
        program_regs(32'd100000, 16'd1000, 16'd3000, 16'd200);
        random_frames(PHASE_ITEMS);

        lo = 16'($urandom_range(0, 3000));
        hi = 16'(lo + $urandom_range(1, 4000));
        program_regs($urandom_range(20000, 32'hFFFF_FFFF), 16'(hi + $urandom_range(0, 8000)),
                     hi, lo);
        random_frames(PHASE_ITEMS);

        program_regs($urandom_range(1, 32'hFFFF_FFFF), 16'($urandom), 16'($urandom),
                     16'($urandom));
        random_frames(PHASE_ITEMS);

        program_regs(32'd65535, 16'd30000, 16'hFFFF, 16'hFFFF);
        random_frames(PHASE_ITEMS);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
